@@ rtl/bbd_pkg.sv @@
// bbd_pkg: shared types and constants of the bucket-brigade delay line
// widths, register indexes, reset values, sequencer states, multiply request
// no dependencies

package bbd_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int ADDR_W     = 12;
    localparam int COEF_W     = 16;
    localparam int MULT_W     = COEF_W + 1;
    localparam int OPER_W     = SAMPLE_W + 1;
    localparam int PROD_W     = MULT_W + 1 + OPER_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_DELAY_WHOLE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_FRAC   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_COEFF = 2'd2;

    localparam logic [ADDR_W-1:0] DELAY_WHOLE_RST  = 12'd2048;
    localparam logic [COEF_W-1:0] DELAY_FRAC_RST   = 16'd0;
    localparam logic [COEF_W-1:0] FILTER_COEFF_RST = 16'd32768;

    localparam logic [MULT_W-1:0] ONE_Q16 = 17'h10000;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PRE,
        S_READ,
        S_TAP,
        S_INTERP,
        S_POST,
        S_OUT
    } t_state;

    // two products summed, rounded half up at bit 16 and saturated
    typedef struct packed {
        logic                     start;
        logic [MULT_W-1:0]        m0;
        logic signed [OPER_W-1:0] s0;
        logic [MULT_W-1:0]        m1;
        logic signed [OPER_W-1:0] s1;
    } t_mac_req;

endpackage

@@ rtl/bbd_ram.sv @@
// bbd_ram: generic synchronous memory, one write port and two read ports
// read data registered, held while the read enable is low
// no dependencies

module bbd_ram #(
    parameter int ADDR_W = 12,
    parameter int DATA_W = 24
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr0,
    input  logic [ADDR_W-1:0] i_rd_addr1,
    output logic [DATA_W-1:0] o_rd_data0,
    output logic [DATA_W-1:0] o_rd_data1
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data0 <= r_mem[i_rd_addr0];
            o_rd_data1 <= r_mem[i_rd_addr1];
        end
    end

endmodule

@@ rtl/bbd_mac.sv @@
// bbd_mac: shared two-product multiply, round and saturate unit
// result = sat(floor((m0*s0 + m1*s1 + 32768) / 65536)), products registered, then the result
// depends on bbd_pkg

module bbd_mac (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  bbd_pkg::t_mac_req                  i_req,
    output logic                               o_done,
    output logic signed [bbd_pkg::SAMPLE_W-1:0] o_result
);

    localparam int SUM_W = bbd_pkg::PROD_W + 1;
    localparam int RND_W = SUM_W - 16;

    logic                               r_prod_vld;
    logic signed [bbd_pkg::PROD_W-1:0]  r_p0;
    logic signed [bbd_pkg::PROD_W-1:0]  r_p1;
    logic signed [SUM_W-1:0]            w_sum;
    logic signed [RND_W-1:0]            w_rnd;
    logic                               w_ovf;
    logic signed [bbd_pkg::SAMPLE_W-1:0] w_sat;

    always_ff @(posedge i_clk) begin
        r_p0 <= $signed({1'b0, i_req.m0}) * i_req.s0;
        r_p1 <= $signed({1'b0, i_req.m1}) * i_req.s1;
    end

    always_comb begin
        w_sum = SUM_W'(r_p0) + SUM_W'(r_p1) + SUM_W'(32768);
        w_rnd = w_sum[SUM_W-1:16];
        w_ovf = (w_rnd[RND_W-1:bbd_pkg::SAMPLE_W-1] != '0) &&
                (w_rnd[RND_W-1:bbd_pkg::SAMPLE_W-1] != '1);
        if (w_ovf) begin
            w_sat = w_rnd[RND_W-1] ? {1'b1, {(bbd_pkg::SAMPLE_W-1){1'b0}}}
                                   : {1'b0, {(bbd_pkg::SAMPLE_W-1){1'b1}}};
        end else begin
            w_sat = w_rnd[bbd_pkg::SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        o_result <= w_sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
            o_done     <= 1'b0;
        end else begin
            r_prod_vld <= i_req.start;
            o_done     <= r_prod_vld;
        end
    end

endmodule

@@ rtl/bbd_delay_line.sv @@
// bbd_delay_line: top level of the bucket-brigade delay emulation
// sequencer, delay store addressing, configuration registers and output register
// depends on bbd_pkg, bbd_mac, bbd_ram

// One signed 24-bit sample per input transfer gives one output transfer. A new sample is
// taken only once the last one has reached the output register; a held output stalls the
// next sample before its output load. The shared multiply unit serves the input lowpass
// (its first stage runs in the transfer cycle), the tap interpolation and the output
// lowpass in turn; each sample goes through the input lowpass, the store write, the
// two-tap read, the tap interpolation, the output lowpass, taking the output lowpass
// result and loading the output register. The delay store needs no clearing pass after
// reset: entries not yet written since reset read as zero, tracked by the write pointer
// and a wrap flag. Configuration writes are always taken and must only be made while no
// sample is in flight.

module bbd_delay_line (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // sample_in [23:0]
    input  logic [bbd_pkg::SAMPLE_W-1:0]        s_axis_tdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // sample_out [23:0]
    output logic [bbd_pkg::SAMPLE_W-1:0]        m_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [bbd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [bbd_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int SW = bbd_pkg::SAMPLE_W;
    localparam int AW = bbd_pkg::ADDR_W;
    localparam int OW = bbd_pkg::OPER_W;

    bbd_pkg::t_state r_state;
    bbd_pkg::t_state n_state;

    logic [AW-1:0]                 r_dly_whole;
    logic [bbd_pkg::COEF_W-1:0]    r_dly_frac;
    logic [bbd_pkg::COEF_W-1:0]    r_coeff;

    logic signed [SW-1:0]          r_pre;
    logic signed [SW-1:0]          r_post;
    logic [AW-1:0]                 r_wr_idx;
    logic                          r_full;
    logic                          r_tap0_ok;
    logic                          r_tap1_ok;
    logic [SW-1:0]                 r_m_data;
    logic                          r_m_valid;

    logic                          w_in_xfer;
    logic                          w_out_free;
    bbd_pkg::t_mac_req             w_req;
    logic                          w_done;
    logic signed [SW-1:0]          w_result;
    logic                          w_wr_en;
    logic                          w_rd_en;
    logic [AW-1:0]                 w_rd_addr0;
    logic [AW-1:0]                 w_rd_addr1;
    logic [SW-1:0]                 w_rd_data0;
    logic [SW-1:0]                 w_rd_data1;
    logic signed [OW-1:0]          w_tap0;
    logic signed [OW-1:0]          w_tap1;
    logic [bbd_pkg::MULT_W-1:0]    w_one_minus_c;

    assign s_axis_tready = (r_state == bbd_pkg::S_IDLE);
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_m_valid || m_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tvalid = r_m_valid;

    assign w_one_minus_c = bbd_pkg::ONE_Q16 - {1'b0, r_coeff};

    // newest tap is write pointer minus one minus delay, older tap one below
    assign w_rd_addr0 = r_wr_idx + ~r_dly_whole;
    assign w_rd_addr1 = w_rd_addr0 - AW'(1);

    assign w_tap0 = r_tap0_ok ? OW'($signed(w_rd_data0)) : '0;
    assign w_tap1 = r_tap1_ok ? OW'($signed(w_rd_data1)) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dly_whole <= bbd_pkg::DELAY_WHOLE_RST;
            r_dly_frac  <= bbd_pkg::DELAY_FRAC_RST;
            r_coeff     <= bbd_pkg::FILTER_COEFF_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                bbd_pkg::REG_DELAY_WHOLE:  r_dly_whole <= i_cfg_data[AW-1:0];
                bbd_pkg::REG_DELAY_FRAC:   r_dly_frac  <= i_cfg_data;
                bbd_pkg::REG_FILTER_COEFF: r_coeff     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            bbd_pkg::S_IDLE: begin
                if (w_in_xfer) n_state = bbd_pkg::S_PRE;
            end
            bbd_pkg::S_PRE: begin
                if (w_done) n_state = bbd_pkg::S_READ;
            end
            bbd_pkg::S_READ: begin
                n_state = bbd_pkg::S_TAP;
            end
            bbd_pkg::S_TAP: begin
                n_state = bbd_pkg::S_INTERP;
            end
            bbd_pkg::S_INTERP: begin
                if (w_done) n_state = bbd_pkg::S_POST;
            end
            bbd_pkg::S_POST: begin
                if (w_done) n_state = bbd_pkg::S_OUT;
            end
            bbd_pkg::S_OUT: begin
                if (w_out_free) n_state = bbd_pkg::S_IDLE;
            end
            default: begin
                n_state = bbd_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        w_req   = '0;
        w_wr_en = 1'b0;
        w_rd_en = 1'b0;
        case (r_state)
            bbd_pkg::S_IDLE: begin
                w_req.start = w_in_xfer;
                w_req.m0    = w_one_minus_c;
                w_req.s0    = OW'($signed(s_axis_tdata));
                w_req.m1    = {1'b0, r_coeff};
                w_req.s1    = OW'(r_pre);
            end
            bbd_pkg::S_PRE: begin
                w_wr_en = w_done;
            end
            bbd_pkg::S_READ: begin
                w_rd_en = 1'b1;
            end
            bbd_pkg::S_TAP: begin
                // t0 + frac * (t1 - t0), t0 scaled up by one in Q1.16
                w_req.start = 1'b1;
                w_req.m0    = bbd_pkg::ONE_Q16;
                w_req.s0    = w_tap0;
                w_req.m1    = {1'b0, r_dly_frac};
                w_req.s1    = w_tap1 - w_tap0;
            end
            bbd_pkg::S_INTERP: begin
                w_req.start = w_done;
                w_req.m0    = w_one_minus_c;
                w_req.s0    = OW'(w_result);
                w_req.m1    = {1'b0, r_coeff};
                w_req.s1    = OW'(r_post);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= bbd_pkg::S_IDLE;
            r_pre     <= '0;
            r_post    <= '0;
            r_wr_idx  <= '0;
            r_full    <= 1'b0;
            r_tap0_ok <= 1'b0;
            r_tap1_ok <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_wr_en) begin
                r_pre    <= w_result;
                r_wr_idx <= r_wr_idx + AW'(1);
                if (r_wr_idx == '1) r_full <= 1'b1;
            end
            if (w_rd_en) begin
                r_tap0_ok <= r_full || (w_rd_addr0 < r_wr_idx);
                r_tap1_ok <= r_full || (w_rd_addr1 < r_wr_idx);
            end
            if (r_state == bbd_pkg::S_POST && w_done) begin
                r_post <= w_result;
            end
            if (r_state == bbd_pkg::S_OUT && w_out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == bbd_pkg::S_OUT && w_out_free) begin
            r_m_data <= r_post;
        end
    end

    bbd_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_req),
        .o_done   (w_done),
        .o_result (w_result)
    );

    bbd_ram #(
        .ADDR_W (AW),
        .DATA_W (SW)
    ) u_store (
        .i_clk      (i_clk),
        .i_wr_en    (w_wr_en),
        .i_wr_addr  (r_wr_idx),
        .i_wr_data  (w_result),
        .i_rd_en    (w_rd_en),
        .i_rd_addr0 (w_rd_addr0),
        .i_rd_addr1 (w_rd_addr1),
        .o_rd_data0 (w_rd_data0),
        .o_rd_data1 (w_rd_data1)
    );

    a_done_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (r_state == bbd_pkg::S_PRE || r_state == bbd_pkg::S_INTERP ||
                    r_state == bbd_pkg::S_POST))
        else $error("multiply unit finished outside a waiting state");

    a_ptr_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |=> (r_wr_idx == $past(r_wr_idx) + AW'(1)))
        else $error("write pointer did not advance on store write");

    a_full_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full |=> r_full)
        else $error("wrap flag cleared without reset");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> (r_state == bbd_pkg::S_PRE))
        else $error("input transfer did not start the input lowpass");

endmodule
